@@ rtl/core/tup_pkg.sv @@
// ----------------------------------------------------------------------------
// tup_pkg
// Shared types, constants and helpers of the texel unpack pipeline.
// ----------------------------------------------------------------------------
package tup_pkg;

    localparam int unsigned LaneCount = 4;

    localparam logic [31:0] OneBits  = 32'h3F80_0000;
    localparam logic [31:0] ZeroBits = 32'h0000_0000;

    // component type codes
    localparam logic [2:0] TypeU8   = 3'd0;
    localparam logic [2:0] TypeS8   = 3'd1;
    localparam logic [2:0] TypeU16  = 3'd2;
    localparam logic [2:0] TypeS16  = 3'd3;
    localparam logic [2:0] TypeU32  = 3'd4;
    localparam logic [2:0] TypeS32  = 3'd5;
    localparam logic [2:0] TypeHalf = 3'd6;
    localparam logic [2:0] TypeF32  = 3'd7;

    // register indexes
    localparam logic [1:0] RegType  = 2'd0;
    localparam logic [1:0] RegNorm  = 2'd1;
    localparam logic [1:0] RegCount = 2'd2;

    // normalize divisors, all of the form 2^n - 1
    localparam logic [15:0] DivU8  = 16'd255;
    localparam logic [15:0] DivS8  = 16'd127;
    localparam logic [15:0] DivU16 = 16'd65535;
    localparam logic [15:0] DivS16 = 16'd32767;

    // exponent of the top fixed-point bit, biased
    localparam logic [7:0] ExpTopRaw  = 8'd158; // 127 + 31
    localparam logic [7:0] ExpTopNorm = 8'd142; // 127 + 15

    typedef struct packed {
        logic        sp;      // direct result, no rounding
        logic [31:0] direct;
        logic        sign;
        logic        nrm;     // fixed point uses normalized scaling
        logic [63:0] mant;
        logic        sticky;
    } t_prep;

    typedef struct packed {
        logic        sp;
        logic [31:0] direct;
        logic        sign;
        logic        zero;
        logic [7:0]  expo;
        logic [23:0] mant;
        logic        guard;
        logic        sticky;
    } t_shft;

    // exact half to single widening
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  s;
        logic [10:0] mw;
        logic [31:0] res;
        sgn = {h[15], 31'd0};
        e   = h[14:10];
        m   = h[9:0];
        s   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                s = 4'(10 - i);
            end
        end
        mw = {1'b0, m} << s;
        if (e == 5'd0) begin
            if (m == 10'd0) begin
                res = sgn;
            end else begin
                res = sgn | {1'b0, 8'(8'd113 - {4'd0, s}), mw[9:0], 13'd0};
            end
        end else if (e == 5'd31) begin
            res = sgn | {1'b0, 8'hFF, m, 13'd0};
        end else begin
            res = sgn | {1'b0, 8'({3'd0, e} + 8'd112), m, 13'd0};
        end
        return res;
    endfunction

endpackage

@@ rtl/core/texel_unpack_to_float.sv @@
// ----------------------------------------------------------------------------
// texel_unpack_to_float
// Unpacks one pixel of up to 16 bytes into a float32 RGBA color.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: i_valid / o_stall with the 16 pixel bytes split over
//    i_pixel_bytes_low and i_pixel_bytes_high. A word is taken at a clock
//    edge with i_valid high and o_stall low.
//  - Output channel: o_valid / i_stall carrying four float32 components and
//    o_format_error. A word leaves at an edge with o_valid high, i_stall low.
//  - APB port sets component type (0x0), normalized flag (0x4) and
//    component count (0x8); write only while the pipeline is empty.
//  - Stages in order: byte gather and fixed-point prep, leading-zero
//    normalize, then round and pack into the output register.
//  - Throughput is one word per cycle while i_stall is low; each stage holds
//    its word while the next is full and stalled, so a stall loses and
//    repeats nothing. o_stall rises only once all three stages hold words.
//  - Synchronous reset empties the pipeline and restores type u8, raw mode,
//    count four.
// ----------------------------------------------------------------------------
module texel_unpack_to_float (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_pixel_bytes_low,
    input  logic [63:0] i_pixel_bytes_high,
    // color output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_red_value,
    output logic [31:0] o_green_value,
    output logic [31:0] o_blue_value,
    output logic [31:0] o_alpha_value,
    output logic        o_format_error,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned Lanes = tup_pkg::LaneCount;

    // configuration registers
    logic [2:0] r_type, r_count;
    logic       r_norm;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= tup_pkg::TypeU8;
            r_norm  <= 1'b0;
            r_count <= 3'd4;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tup_pkg::RegType:  r_type  <= pwdata[2:0];
                tup_pkg::RegNorm:  r_norm  <= pwdata[0];
                tup_pkg::RegCount: r_count <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tup_pkg::RegType:  prdata = {29'd0, r_type};
            tup_pkg::RegNorm:  prdata = {31'd0, r_norm};
            tup_pkg::RegCount: prdata = {29'd0, r_count};
            default:           prdata = 32'd0;
        endcase
    end

    // pipeline flow control: a stage loads when empty or draining
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3    = !r_v3 || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // stage 1: gather components and prepare fixed point
    logic [7:0]  bytes [16];
    logic [31:0] raw [Lanes];
    logic        err;
    logic [31:0] dflt [Lanes];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            bytes[k]     = i_pixel_bytes_low[8*k +: 8];
            bytes[k + 8] = i_pixel_bytes_high[8*k +: 8];
        end
        for (int i = 0; i < Lanes; i++) begin
            case (r_type)
                tup_pkg::TypeU8, tup_pkg::TypeS8:
                    raw[i] = {24'd0, bytes[i]};
                tup_pkg::TypeU16, tup_pkg::TypeS16, tup_pkg::TypeHalf:
                    raw[i] = {16'd0, bytes[2*i + 1], bytes[2*i]};
                default:
                    raw[i] = {bytes[4*i + 3], bytes[4*i + 2], bytes[4*i + 1], bytes[4*i]};
            endcase
            dflt[i] = (i == Lanes - 1) ? tup_pkg::OneBits : tup_pkg::ZeroBits;
        end
    end

    // normalized mode only covers the 8 and 16 bit integer types
    assign err = r_norm && r_type[2];

    tup_pkg::t_prep prep [Lanes];
    tup_pkg::t_prep r_prep [Lanes];
    tup_pkg::t_shft shft [Lanes];
    tup_pkg::t_shft r_shft [Lanes];
    logic [31:0]    color [Lanes];
    logic           r_err1, r_err2;
    logic [31:0]    r_color [Lanes];

    for (genvar g = 0; g < Lanes; g++) begin : g_lane
        tup_lane_prep u_prep (
            .i_type    (r_type),
            .i_norm    (r_norm),
            .i_active  (!err && (3'(g) < r_count)),
            .i_raw     (raw[g]),
            .i_default (dflt[g]),
            .o_prep    (prep[g])
        );

        tup_lane_shift u_shift (
            .i_prep (r_prep[g]),
            .o_shft (shft[g])
        );

        tup_lane_round u_round (
            .i_shft  (r_shft[g]),
            .o_value (color[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_prep <= prep;
            r_err1 <= err;
        end
        if (rdy2) begin
            r_shft <= shft;
            r_err2 <= r_err1;
        end
        if (rdy3) begin
            r_color        <= color;
            o_format_error <= r_err2;
        end
    end

    assign o_red_value   = r_color[0];
    assign o_green_value = r_color[1];
    assign o_blue_value  = r_color[2];
    assign o_alpha_value = r_color[3];

`ifndef ASSERT_OFF
    a_err_defaults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_format_error) |-> (o_red_value == tup_pkg::ZeroBits &&
        o_green_value == tup_pkg::ZeroBits && o_blue_value == tup_pkg::ZeroBits &&
        o_alpha_value == tup_pkg::OneBits))
        else $error("format error word without default color");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && i_stall))
        else $error("input stalled with room in the pipeline");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && i_stall) |=> r_v2 && r_v3)
        else $error("stalled pipeline dropped a word");
`endif

endmodule

@@ rtl/core/tup_lane_prep.sv @@
// ----------------------------------------------------------------------------
// tup_lane_prep
// Stage one of a lane: sign and magnitude, exact fixed-point quotient, or a direct float32 result.
// ----------------------------------------------------------------------------
module tup_lane_prep (
    input  logic [2:0]           i_type,
    input  logic                 i_norm,
    input  logic                 i_active,
    input  logic [31:0]          i_raw,
    input  logic [31:0]          i_default,
    output tup_pkg::t_prep       o_prep
);

    logic [15:0] mag16;
    logic [15:0] div;
    logic        whole;
    logic [15:0] rem;
    logic [47:0] pat8, pat7, pat16, pat15, pat;
    logic        s8, s16, s32;

    assign s8  = i_raw[7];
    assign s16 = i_raw[15];
    assign s32 = i_raw[31];

    always_comb begin
        case (i_type)
            tup_pkg::TypeU8:  begin mag16 = {8'd0, i_raw[7:0]};             div = tup_pkg::DivU8;  end
            tup_pkg::TypeS8:  begin
                mag16 = {8'd0, s8 ? 8'(~i_raw[7:0] + 8'd1) : i_raw[7:0]};
                div   = tup_pkg::DivS8;
            end
            tup_pkg::TypeU16: begin mag16 = i_raw[15:0];                    div = tup_pkg::DivU16; end
            default: begin
                mag16 = s16 ? 16'(~i_raw[15:0] + 16'd1) : i_raw[15:0];
                div   = tup_pkg::DivS16;
            end
        endcase
    end

    // x / (2^n - 1) = whole + rem repeated every n bits after the point
    assign whole = (mag16 >= div);
    assign rem   = whole ? 16'(mag16 - div) : mag16;

    always_comb begin
        for (int j = 0; j < 48; j++) begin
            pat8[47 - j]  = rem[7 - (j % 8)];
            pat7[47 - j]  = rem[6 - (j % 7)];
            pat16[47 - j] = rem[15 - (j % 16)];
            pat15[47 - j] = rem[14 - (j % 15)];
        end
        case (i_type)
            tup_pkg::TypeU8:  pat = pat8;
            tup_pkg::TypeS8:  pat = pat7;
            tup_pkg::TypeU16: pat = pat16;
            default:          pat = pat15;
        endcase
    end

    always_comb begin
        o_prep        = '0;
        o_prep.direct = i_default;
        if (!i_active) begin
            o_prep.sp = 1'b1;
        end else if (i_norm) begin
            o_prep.nrm    = 1'b1;
            o_prep.sign   = (i_type == tup_pkg::TypeS8) ? s8 :
                            (i_type == tup_pkg::TypeS16) ? s16 : 1'b0;
            o_prep.mant   = {15'd0, whole, pat};
            o_prep.sticky = (rem != 16'd0);
        end else begin
            case (i_type)
                tup_pkg::TypeU8:  o_prep.mant = {24'd0, i_raw[7:0], 32'd0};
                tup_pkg::TypeS8: begin
                    o_prep.sign = s8;
                    o_prep.mant = {16'd0, mag16, 32'd0};
                end
                tup_pkg::TypeU16: o_prep.mant = {16'd0, i_raw[15:0], 32'd0};
                tup_pkg::TypeS16: begin
                    o_prep.sign = s16;
                    o_prep.mant = {16'd0, mag16, 32'd0};
                end
                tup_pkg::TypeU32: o_prep.mant = {i_raw, 32'd0};
                tup_pkg::TypeS32: begin
                    o_prep.sign = s32;
                    o_prep.mant = {s32 ? 32'(~i_raw + 32'd1) : i_raw, 32'd0};
                end
                tup_pkg::TypeHalf: begin
                    o_prep.sp     = 1'b1;
                    o_prep.direct = tup_pkg::half_to_single(i_raw[15:0]);
                end
                default: begin
                    o_prep.sp     = 1'b1;
                    o_prep.direct = i_raw;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/tup_lane_shift.sv @@
// ----------------------------------------------------------------------------
// tup_lane_shift
// Stage two of a lane: leading-zero count and normalizing shift.
// ----------------------------------------------------------------------------
module tup_lane_shift (
    input  tup_pkg::t_prep i_prep,
    output tup_pkg::t_shft o_shft
);

    logic [5:0]  lz;
    logic [63:0] sh;

    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (i_prep.mant[i]) begin
                lz = 6'(63 - i);
            end
        end
    end

    assign sh = i_prep.mant << lz;

    always_comb begin
        o_shft.sp     = i_prep.sp;
        o_shft.direct = i_prep.direct;
        o_shft.sign   = i_prep.sign;
        o_shft.zero   = (i_prep.mant == 64'd0);
        o_shft.expo   = 8'((i_prep.nrm ? tup_pkg::ExpTopNorm : tup_pkg::ExpTopRaw) - {2'd0, lz});
        o_shft.mant   = sh[63:40];
        o_shft.guard  = sh[39];
        o_shft.sticky = (sh[38:0] != 39'd0) | i_prep.sticky;
    end

endmodule

@@ rtl/core/tup_lane_round.sv @@
// ----------------------------------------------------------------------------
// tup_lane_round
// Stage three of a lane: round to nearest even and pack float32.
// ----------------------------------------------------------------------------
module tup_lane_round (
    input  tup_pkg::t_shft i_shft,
    output logic [31:0]    o_value
);

    logic        inc;
    logic [24:0] sum;
    logic [7:0]  expo;
    logic [22:0] frac;

    assign inc  = i_shft.guard & (i_shft.sticky | i_shft.mant[0]);
    assign sum  = {1'b0, i_shft.mant} + {24'd0, inc};
    assign expo = sum[24] ? 8'(i_shft.expo + 8'd1) : i_shft.expo;
    assign frac = sum[24] ? sum[23:1] : sum[22:0];

    always_comb begin
        if (i_shft.sp) begin
            o_value = i_shft.direct;
        end else if (i_shft.zero) begin
            o_value = tup_pkg::ZeroBits;
        end else begin
            o_value = {i_shft.sign, expo, frac};
        end
    end

endmodule

@@ bench/texel_color_check.sv @@
// ----------------------------------------------------------------------------
// texel_color_check
// Watches the pixel and color channels and the APB port, predicts each color
// word from the snooped register values and compares it with the DUT output.
// ----------------------------------------------------------------------------
module texel_color_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [63:0] i_pixel_bytes_low,
    input  logic [63:0] i_pixel_bytes_high,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_red_value,
    input  logic [31:0] i_green_value,
    input  logic [31:0] i_blue_value,
    input  logic [31:0] i_alpha_value,
    input  logic        i_format_error,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [31:0] comp[4];
        logic        err;
    } t_color;

    logic [2:0] cfg_type;
    logic       cfg_norm;
    logic [2:0] cfg_count;
    t_color     colors_due[$];

    // double to float32, round to nearest even; values seen here are normal or zero
    function automatic logic [31:0] real_to_f32(input real r);
        logic [63:0] d;
        logic [52:0] full;
        logic [24:0] keep;
        logic [7:0]  e;
        d = $realtobits(r);
        if (d[62:0] == 63'd0) begin
            return {d[63], 31'd0};
        end
        full = {1'b1, d[51:0]};
        e    = 8'(d[62:52] - 11'd1023 + 11'd127);
        keep = {1'b0, full[52:29]};
        if (full[28] && ((|full[27:0]) || keep[0])) begin
            keep = keep + 25'd1;
        end
        if (keep[24]) begin
            keep = keep >> 1;
            e    = e + 8'd1;
        end
        return {d[63], e, keep[22:0]};
    endfunction

    function automatic logic [31:0] half_widen(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  e;
        logic [10:0] m;
        int          shift;
        sgn = {h[15], 31'd0};
        e   = h[14:10];
        m   = {1'b0, h[9:0]};
        if (e == 5'd31) begin
            return sgn | 32'h7F80_0000 | {9'd0, m[9:0], 13'd0};
        end
        if (e != 5'd0) begin
            return sgn | {1'b0, 8'(e + 8'd112), m[9:0], 13'd0};
        end
        if (m == 11'd0) begin
            return sgn;
        end
        shift = 0;
        while (!m[10]) begin
            m     = m << 1;
            shift = shift + 1;
        end
        return sgn | {1'b0, 8'(113 - shift), m[9:0], 13'd0};
    endfunction

    function automatic t_color unpack_pixel(input logic [2:0] ty, input logic nm,
                                            input logic [2:0] cnt,
                                            input logic [63:0] lo, input logic [63:0] hi);
        t_color      c;
        logic [127:0] px;
        logic [31:0] raw;
        int          size;
        int          n;
        longint      val;
        px     = {hi, lo};
        c.comp = '{tup_pkg::ZeroBits, tup_pkg::ZeroBits, tup_pkg::ZeroBits,
                   tup_pkg::OneBits};
        c.err  = nm && (ty >= tup_pkg::TypeU32);
        size   = (ty <= tup_pkg::TypeS8) ? 1 :
                 (ty == tup_pkg::TypeU16 || ty == tup_pkg::TypeS16 ||
                  ty == tup_pkg::TypeHalf) ? 2 : 4;
        n      = (cnt > 3'd4) ? 4 : int'(cnt);
        if (!c.err) begin
            for (int i = 0; i < n; i++) begin
                raw = px[i*size*8 +: 32];
                case (ty)
                    tup_pkg::TypeU8:  val = longint'(raw[7:0]);
                    tup_pkg::TypeS8:  val = longint'($signed(raw[7:0]));
                    tup_pkg::TypeU16: val = longint'(raw[15:0]);
                    tup_pkg::TypeS16: val = longint'($signed(raw[15:0]));
                    tup_pkg::TypeU32: val = longint'(raw);
                    default:          val = longint'($signed(raw));
                endcase
                if (ty == tup_pkg::TypeHalf) begin
                    c.comp[i] = half_widen(raw[15:0]);
                end else if (ty == tup_pkg::TypeF32) begin
                    c.comp[i] = raw;
                end else if (!nm) begin
                    c.comp[i] = real_to_f32(real'(val));
                end else begin
                    case (ty)
                        tup_pkg::TypeU8:  c.comp[i] = real_to_f32(real'(val) / 255.0);
                        tup_pkg::TypeS8:  c.comp[i] = real_to_f32(real'(val) / 127.0);
                        tup_pkg::TypeU16: c.comp[i] = real_to_f32(real'(val) / 65535.0);
                        default:          c.comp[i] = real_to_f32(real'(val) / 32767.0);
                    endcase
                end
            end
        end
        return c;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            o_fail_count++;
        end
    endtask

    assign o_pending = colors_due.size();

    always @(posedge i_clk) begin
        t_color c;
        if (!i_rst_n) begin
            cfg_type     <= tup_pkg::TypeU8;
            cfg_norm     <= 1'b0;
            cfg_count    <= 3'd4;
            o_fail_count <= 0;
            colors_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (colors_due.size() == 0) begin
                    $error("color word with none expected");
                    o_fail_count++;
                end else begin
                    c = colors_due.pop_front();
                    compare_field("red_value", c.comp[0], i_red_value);
                    compare_field("green_value", c.comp[1], i_green_value);
                    compare_field("blue_value", c.comp[2], i_blue_value);
                    compare_field("alpha_value", c.comp[3], i_alpha_value);
                    compare_field("format_error", 32'(c.err), 32'(i_format_error));
                end
            end
            if (i_valid && !i_in_stall) begin
                colors_due.push_back(unpack_pixel(cfg_type, cfg_norm, cfg_count,
                                                  i_pixel_bytes_low, i_pixel_bytes_high));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    tup_pkg::RegType:  cfg_type  <= i_pwdata[2:0];
                    tup_pkg::RegNorm:  cfg_norm  <= i_pwdata[0];
                    tup_pkg::RegCount: cfg_count <= i_pwdata[2:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel words and APB register writes into texel_unpack_to_float with
// random gaps and stalls; the checker beside the DUT predicts every color.
// ----------------------------------------------------------------------------
module tb_top;

    // index past the register list, writes there must be ignored
    localparam logic [1:0] RegSpare = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_pixel_bytes_low = '0;
    logic [63:0] i_pixel_bytes_high = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_red_value, o_green_value, o_blue_value, o_alpha_value;
    logic        o_format_error;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    // calm phases: no gaps on either side
    bit          calm = 1'b0;

    always #5 i_clk = ~i_clk;

    texel_unpack_to_float dut (.*);

    texel_color_check checker_i (
        .i_clk, .i_rst_n, .i_valid,
        .i_in_stall(o_stall),
        .i_pixel_bytes_low, .i_pixel_bytes_high,
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_red_value(o_red_value), .i_green_value(o_green_value),
        .i_blue_value(o_blue_value), .i_alpha_value(o_alpha_value),
        .i_format_error(o_format_error),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // APB write: setup cycle, then access cycle; pready is always high
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one pixel word; valid stays high into the next word when there is no gap
    task automatic send_pixel(input logic [63:0] lo, input logic [63:0] hi);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_pixel_bytes_low  <= lo;
        i_pixel_bytes_high <= hi;
        do @(posedge i_clk); while (o_stall);
    endtask

    // let the pipeline empty before touching the registers
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // bytes biased toward 00, FF, 80, 7F so sign and range edges show up often
    function automatic logic [63:0] pixel_half();
        logic [63:0] w;
        for (int b = 0; b < 8; b++) begin
            case ($urandom_range(0, 5))
                0:       w[b*8 +: 8] = 8'h00;
                1:       w[b*8 +: 8] = 8'hFF;
                2:       w[b*8 +: 8] = 8'h80;
                3:       w[b*8 +: 8] = 8'h7F;
                default: w[b*8 +: 8] = 8'($urandom);
            endcase
        end
        return w;
    endfunction

    // receiver: per word a stall at random, none in calm phases, then take it
    initial begin
        int n;
        forever begin
            n = calm ? 0 : $urandom_range(0, 7);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        #3_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        logic [2:0] ty;
        logic [2:0] cnt;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset setting (u8 raw, four components), byte extremes
        send_pixel(64'h0, 64'h0);
        send_pixel('1, '1);
        send_pixel(64'h8080_8080_7F7F_7F7F, 64'h0123_4567_89AB_CDEF);
        drain();
        // signed 8-bit normalized: -128 stays below -1
        reg_write(tup_pkg::RegType, 32'(tup_pkg::TypeS8));
        reg_write(tup_pkg::RegNorm, 32'd1);
        send_pixel(64'h0000_0000_7F01_FF80, '1);
        send_pixel(64'h8080_8080_8080_8080, 64'h0);
        drain();
        // half float: infinities, NaNs, subnormals, zeros
        reg_write(tup_pkg::RegType, 32'(tup_pkg::TypeHalf));
        reg_write(tup_pkg::RegNorm, 32'd0);
        send_pixel(64'h7E01_FC00_7C00_8000, 64'h0);
        send_pixel(64'h83FF_0001_0200_03FF, 64'h0);
        send_pixel(64'h7BFF_FBFF_3C00_0400, '1);
        drain();
        // float32 NaN passes through; count zero and above four
        reg_write(tup_pkg::RegType, 32'(tup_pkg::TypeF32));
        send_pixel(64'hFFC0_0001_7F80_0001, 64'h7FFF_FFFF_0000_0000);
        drain();
        reg_write(tup_pkg::RegCount, 32'd0);
        send_pixel('1, '1);
        drain();
        reg_write(tup_pkg::RegCount, 32'd7);
        send_pixel(64'h3F80_0000_BF80_0000, 64'h8000_0000_0000_0001);
        drain();
        // u32 / s32 extremes and rounding
        reg_write(tup_pkg::RegType, 32'(tup_pkg::TypeU32));
        send_pixel(64'hFFFF_FFFF_0100_0001, 64'h8000_0000_00FF_FFFF);
        drain();
        reg_write(tup_pkg::RegType, 32'(tup_pkg::TypeS32));
        send_pixel(64'hFFFF_FFFF_8000_0000, 64'h7FFF_FFFF_0100_0003);
        drain();
        // normalized with a 32-bit type flags an error; spare index is ignored
        reg_write(tup_pkg::RegNorm, 32'd1);
        reg_write(RegSpare, '1);
        send_pixel('1, '1);
        drain();
        // 16-bit normalized extremes
        reg_write(tup_pkg::RegType, 32'(tup_pkg::TypeS16));
        send_pixel(64'h8000_7FFF_0001_FFFF, 64'h0);
        drain();
        reg_write(tup_pkg::RegType, 32'(tup_pkg::TypeU16));
        send_pixel(64'h8000_7FFF_0001_FFFF, 64'h0);
        drain();

        // random phases over every type and mode, with counts of zero, one to four and five to seven
        for (int ph = 0; ph < 32; ph++) begin
            ty  = 3'(ph % 8);
            cnt = (ph % 5 == 0) ? 3'd0 : (ph % 7 == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(1, 4));
            reg_write(tup_pkg::RegType, {29'($urandom), ty});
            reg_write(tup_pkg::RegNorm, {31'($urandom), 1'(ph / 8 % 2)});
            reg_write(tup_pkg::RegCount, {29'($urandom), cnt});
            calm = (ph % 6 == 3);
            for (int k = 0; k < 37; k++) begin
                send_pixel(pixel_half(), pixel_half());
                // one mid-phase pause until every color has come back
                if (ph == 10 && k == 18) begin
                    drain();
                end
            end
            drain();
        end
        calm = 1'b0;

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/tup_pkg.sv
rtl/core/tup_lane_prep.sv
rtl/core/tup_lane_shift.sv
rtl/core/tup_lane_round.sv
rtl/core/texel_unpack_to_float.sv
bench/texel_color_check.sv
bench/tb_top.sv
